// ----- rtl/fap_pkg.sv -----
// fap_pkg: types and constants shared by the frame acknowledgment block
// no dependencies

package fap_pkg;

    localparam int unsigned ACK_LEN = 17;
    localparam logic [4:0]  POS_MAX = 5'd31;
    localparam logic [7:0]  ACK_B0 = 8'h02;
    localparam logic [7:0]  ACK_B1 = 8'h00;
    localparam logic [2:0]  FT_DATA = 3'd1;
    localparam logic [2:0]  FT_ACK = 3'd2;
    localparam int unsigned ACK_REQ_BIT = 5;

    localparam logic [4:0]  POS_SEQ = 5'd2;
    localparam logic [4:0]  POS_SRC_LO = 5'd3;
    localparam logic [4:0]  POS_SRC_HI = 5'd10;
    localparam logic [4:0]  POS_DST_LO = 5'd5;
    localparam logic [4:0]  POS_DST_HI = 5'd12;
    localparam logic [4:0]  POS_TIM_LO = 5'd11;
    localparam logic [4:0]  POS_TIM_HI = 5'd16;

    localparam logic [4:0]  ACK_POS_SEQ = 5'd2;
    localparam logic [4:0]  ACK_POS_ADR_HI = 5'd10;
    localparam logic [4:0]  ACK_POS_PH_LO = 5'd11;
    localparam logic [4:0]  ACK_POS_PH_HI = 5'd12;
    localparam logic [4:0]  ACK_POS_CYC_LO = 5'd13;
    localparam logic [4:0]  ACK_POS_LAST = 5'd16;

    typedef enum logic [1:0] {
        CFG_OWN_ADDR = 2'd0,
        CFG_AWAITED  = 2'd1,
        CFG_IS_ROOT  = 2'd2,
        CFG_CYC_LEN  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        K_NONE    = 2'd0,
        K_TARGETS = 2'd1,
        K_ACK     = 2'd2
    } t_kind;

    typedef struct packed {
        logic [63:0] own_addr;
        logic [63:0] awaited;
        logic        is_root;
        logic [31:0] cyc_len;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  seq;
        logic [15:0] phase;
        logic [31:0] cycle;
    } t_dec;

    typedef struct packed {
        logic full;
        logic empty;
        logic push;
    } t_qstat;

endpackage

// ----- rtl/fap_front.sv -----
// fap_front: byte parser, tracks position and address matches, decides at frame end
// depends on fap_pkg

module fap_front
    import fap_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic        i_start,
    input  logic        i_end,
    input  logic [15:0] i_now,
    input  logic [15:0] i_cstart,
    output logic        o_push,
    output t_dec        o_dec
);

    logic [4:0]  r_pos, n_pos;
    logic [7:0]  r_fc, n_fc;
    logic [7:0]  r_seq, n_seq;
    logic        r_dm, n_dm;
    logic        r_am, n_am;
    logic [47:0] r_cap, n_cap;

    logic [4:0]  w_pos;
    logic [7:0]  w_fc, w_seq;
    logic        w_dm, w_am;
    logic [47:0] w_cap;
    logic [2:0]  w_src_idx, w_dst_idx, w_tim_idx;
    logic [15:0] w_diff, w_phase;
    logic        w_want_ack, w_targets;

    always_comb begin
        w_pos = i_start ? '0 : r_pos;
        w_src_idx = 3'(POS_SRC_HI - w_pos);
        w_dst_idx = 3'(w_pos - POS_DST_LO);
        w_tim_idx = 3'(w_pos - POS_TIM_LO);

        w_fc = (w_pos == '0) ? i_byte : r_fc;
        w_seq = (w_pos == POS_SEQ) ? i_byte : (i_start ? '0 : r_seq);

        w_am = i_start ? 1'b1 : r_am;
        if (w_pos >= POS_SRC_LO && w_pos <= POS_SRC_HI
            && i_cfg.awaited[{w_src_idx, 3'b000} +: 8] != i_byte) begin
            w_am = 1'b0;
        end
        w_dm = i_start ? 1'b1 : r_dm;
        if (w_pos >= POS_DST_LO && w_pos <= POS_DST_HI
            && i_cfg.own_addr[{w_dst_idx, 3'b000} +: 8] != i_byte) begin
            w_dm = 1'b0;
        end

        w_cap = r_cap;
        for (int k = 0; k < 6; k++) begin
            if (w_pos >= POS_TIM_LO && w_pos <= POS_TIM_HI && w_tim_idx == 3'(k)) begin
                w_cap[8*k +: 8] = i_byte;
            end
        end

        // wrapping compare of cycle start against arrival
        w_diff = i_cstart - i_now;
        w_phase = (!i_cfg.is_root && w_diff[15]) ? (i_now - i_cstart) : '0;

        w_want_ack = (w_fc[2:0] == FT_DATA) && w_fc[ACK_REQ_BIT]
                     && (w_pos >= POS_DST_HI) && w_dm;
        w_targets = (w_fc[2:0] == FT_ACK) && (w_pos >= POS_TIM_HI) && w_am;
    end

    always_comb begin
        o_push = i_accept && i_end;
        o_dec.seq = w_seq;
        priority if (w_want_ack) begin
            o_dec.kind = K_ACK;
            o_dec.phase = w_phase;
            o_dec.cycle = i_cfg.cyc_len;
        end else if (w_targets) begin
            o_dec.kind = K_TARGETS;
            o_dec.phase = w_cap[15:0];
            o_dec.cycle = w_cap[47:16];
        end else begin
            o_dec.kind = K_NONE;
            o_dec.phase = '0;
            o_dec.cycle = '0;
        end
    end

    always_comb begin
        n_pos = r_pos;
        n_fc = r_fc;
        n_seq = r_seq;
        n_dm = r_dm;
        n_am = r_am;
        n_cap = r_cap;
        if (i_accept) begin
            if (i_end) begin
                n_pos = '0;
                n_fc = '0;
                n_seq = '0;
                n_dm = 1'b1;
                n_am = 1'b1;
            end else begin
                n_pos = (w_pos < POS_MAX) ? w_pos + 5'd1 : POS_MAX;
                n_fc = w_fc;
                n_seq = w_seq;
                n_dm = w_dm;
                n_am = w_am;
                n_cap = w_cap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_fc <= '0;
            r_seq <= '0;
            r_dm <= 1'b1;
            r_am <= 1'b1;
        end else begin
            r_pos <= n_pos;
            r_fc <= n_fc;
            r_seq <= n_seq;
            r_dm <= n_dm;
            r_am <= n_am;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cap <= n_cap;
    end

endmodule

// ----- rtl/fap_queue.sv -----
// fap_queue: two-entry queue of frame decisions between parser and emitter
// depends on fap_pkg

module fap_queue
    import fap_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_dec   i_dec,
    input  logic   i_pop,
    output t_dec   o_head,
    output t_qstat o_stat
);

    t_dec       r_mem [2];
    logic       r_wr, n_wr;
    logic       r_rd, n_rd;
    logic [1:0] r_cnt, n_cnt;
    logic       w_push, w_pop;

    always_comb begin
        w_push = i_push && (r_cnt != 2'd2);
        w_pop = i_pop && (r_cnt != 2'd0);
        n_wr = w_push ? ~r_wr : r_wr;
        n_rd = w_pop ? ~r_rd : r_rd;
        n_cnt = r_cnt + 2'(w_push) - 2'(w_pop);
        o_head = r_mem[r_rd];
        o_stat.full = (r_cnt == 2'd2);
        o_stat.empty = (r_cnt == 2'd0);
        o_stat.push = i_push;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= 1'b0;
            r_rd <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_dec;
        end
    end

endmodule

// ----- rtl/fap_back.sv -----
// fap_back: turns queued decisions into result transactions, 17 for an acknowledgment
// depends on fap_pkg

module fap_back
    import fap_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [63:0] i_own_addr,
    input  t_dec        i_head,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_ack_valid,
    output logic [7:0]  o_ack_byte,
    output logic        o_last,
    output logic        o_tgt_valid,
    output logic [15:0] o_phase,
    output logic [31:0] o_cycle
);

    logic [4:0]  r_cnt, n_cnt;
    logic        r_valid, n_valid;
    logic        r_ack_valid, r_last, r_tgt_valid;
    logic [7:0]  r_ack_byte;
    logic [15:0] r_phase;
    logic [31:0] r_cycle;
    logic        w_emit, w_is_ack, w_final;
    logic [7:0]  w_byte;
    logic [2:0]  w_adr_idx;
    logic [1:0]  w_cyc_idx;

    always_comb begin
        w_emit = (!r_valid || i_ready) && !i_empty;
        w_is_ack = (i_head.kind == K_ACK);
        w_final = !w_is_ack || (r_cnt == ACK_POS_LAST);
        w_adr_idx = 3'(ACK_POS_ADR_HI - r_cnt);
        w_cyc_idx = 2'(r_cnt - ACK_POS_CYC_LO);
        priority if (r_cnt == '0) begin
            w_byte = ACK_B0;
        end else if (r_cnt == 5'd1) begin
            w_byte = ACK_B1;
        end else if (r_cnt == ACK_POS_SEQ) begin
            w_byte = i_head.seq;
        end else if (r_cnt <= ACK_POS_ADR_HI) begin
            w_byte = i_own_addr[{w_adr_idx, 3'b000} +: 8];
        end else if (r_cnt == ACK_POS_PH_LO) begin
            w_byte = i_head.phase[7:0];
        end else if (r_cnt == ACK_POS_PH_HI) begin
            w_byte = i_head.phase[15:8];
        end else begin
            w_byte = i_head.cycle[{w_cyc_idx, 3'b000} +: 8];
        end
        o_pop = w_emit && w_final;
        n_cnt = r_cnt;
        if (w_emit) begin
            n_cnt = w_final ? '0 : r_cnt + 5'd1;
        end
        n_valid = w_emit ? 1'b1 : (i_ready ? 1'b0 : r_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_valid <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_ack_valid <= w_is_ack;
            r_ack_byte <= w_is_ack ? w_byte : 8'h00;
            r_last <= w_final;
            r_tgt_valid <= (i_head.kind == K_TARGETS);
            r_phase <= w_is_ack ? 16'h0000 : i_head.phase;
            r_cycle <= w_is_ack ? 32'h0000_0000 : i_head.cycle;
        end
    end

    assign o_valid = r_valid;
    assign o_ack_valid = r_ack_valid;
    assign o_ack_byte = r_ack_byte;
    assign o_last = r_last;
    assign o_tgt_valid = r_tgt_valid;
    assign o_phase = r_phase;
    assign o_cycle = r_cycle;

endmodule

// ----- rtl/frame_ack_with_phase_info_top.sv -----
// frame_ack_with_phase_info_top: configuration registers, parser, decision queue, emitter
// depends on fap_pkg, fap_front, fap_queue, fap_back

// Usage
// Input stream: one received frame byte per transaction. tdata holds frame_byte,
// now_time and cycle_start_time, tuser holds frame_start and tlast marks frame_end.
// Bytes that are not the last of a frame produce no output. The last byte of a
// frame produces either a 17-transaction acknowledgment (tuser bit 0 set, tlast on
// the final byte) or a single transaction with tlast set, carrying learned phase
// and cycle targets when tuser bit 1 is set.
// Path: the decision for the last byte enters the decision queue; the emitter then registers its first result.
// Throughput: one input byte per cycle; the emitter gives one result per cycle while
// the output is ready. A two-entry decision queue lets the parser keep taking bytes
// while an acknowledgment is emitted; tready drops only when the queue is full.
// Output stall: the result register holds until taken; the emitter and then the
// queue back up, the parser is not held otherwise.
// Configuration: index/data write channel, always ready; write only while idle.
// Reset (synchronous, active low): configuration registers cleared, parser at byte 0, queue and
// output empty.

module frame_ack_with_phase_info_top
    import fap_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // frame_byte[7:0], now_time[23:8], cycle_start_time[39:24]
    input  logic        i_s_axis_tuser,   // frame_start
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // ack_byte[7:0], learned_phase[23:8], learned_cycle[55:24]
    output logic [1:0]  o_m_axis_tuser,   // ack_valid[0], targets_valid[1]
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_cfg   r_cfg;
    t_dec   w_dec, w_head;
    t_qstat w_qstat;
    logic   w_accept, w_push, w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_OWN_ADDR: r_cfg.own_addr <= i_cfg_data;
                CFG_AWAITED:  r_cfg.awaited <= i_cfg_data;
                CFG_IS_ROOT:  r_cfg.is_root <= i_cfg_data[0];
                CFG_CYC_LEN:  r_cfg.cyc_len <= i_cfg_data[31:0];
                default:      r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_s_axis_tready = !w_qstat.full;
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    fap_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (w_accept),
        .i_byte   (i_s_axis_tdata[7:0]),
        .i_start  (i_s_axis_tuser),
        .i_end    (i_s_axis_tlast),
        .i_now    (i_s_axis_tdata[23:8]),
        .i_cstart (i_s_axis_tdata[39:24]),
        .o_push   (w_push),
        .o_dec    (w_dec)
    );

    fap_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_dec   (w_dec),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_qstat)
    );

    fap_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_own_addr  (r_cfg.own_addr),
        .i_head      (w_head),
        .i_empty     (w_qstat.empty),
        .o_pop       (w_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_ack_valid (o_m_axis_tuser[0]),
        .o_ack_byte  (o_m_axis_tdata[7:0]),
        .o_last      (o_m_axis_tlast),
        .o_tgt_valid (o_m_axis_tuser[1]),
        .o_phase     (o_m_axis_tdata[23:8]),
        .o_cycle     (o_m_axis_tdata[55:24])
    );

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.push |-> !w_qstat.full)
        else $error("decision pushed into full queue");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("pop from empty queue");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("acknowledgment byte flagged with targets");

    a_sole_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> o_m_axis_tlast)
        else $error("non-acknowledgment result without tlast");
`endif

endmodule

// ----- tb/fap_result_checker.sv -----
// fap_result_checker: follows the byte stream and register writes, predicts every result
// transaction of the frame acknowledgment block and compares it with the output stream
// depends on fap_pkg

module fap_result_checker
    import fap_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // frame_byte[7:0], now_time[23:8], cycle_start_time[39:24]
    input  logic        i_s_axis_tuser,   // frame_start
    input  logic        i_s_axis_tlast,
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [55:0] i_m_axis_tdata,   // ack_byte[7:0], learned_phase[23:8], learned_cycle[55:24]
    input  logic [1:0]  i_m_axis_tuser,   // ack_valid[0], targets_valid[1]
    input  logic        i_m_axis_tlast,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_rows_pending
);

    typedef struct packed {
        logic        ack_valid;
        logic [7:0]  ack_byte;
        logic        ack_last;
        logic        targets_valid;
        logic [15:0] learned_phase;
        logic [31:0] learned_cycle;
    } t_result_row;

    t_cfg        regs = '0;
    logic [4:0]  byte_pos;
    logic [7:0]  frame_ctl;
    logic [7:0]  seq_num;
    logic        dst_match;
    logic        src_match;
    logic [47:0] timing_bytes;
    t_result_row rows_due[$];
    int          fail_count = 0;

    function automatic void clear_parser();
        byte_pos     = '0;
        frame_ctl    = '0;
        seq_num      = '0;
        dst_match    = 1'b1;
        src_match    = 1'b1;
        timing_bytes = '0;
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic at_start,
                                         input logic at_end, input logic [15:0] now,
                                         input logic [15:0] cstart);
        int          p;
        int          len;
        logic [15:0] gap;
        logic [15:0] phase;
        logic [7:0]  ack [ACK_LEN];
        t_result_row row;
        if (at_start) clear_parser();
        p = byte_pos;
        if (p == 0) frame_ctl = b;
        else if (p == POS_SEQ) seq_num = b;
        if (p >= POS_SRC_LO && p <= POS_SRC_HI && regs.awaited[8*(POS_SRC_HI-p) +: 8] != b)
            src_match = 1'b0;
        if (p >= POS_DST_LO && p <= POS_DST_HI && regs.own_addr[8*(p-POS_DST_LO) +: 8] != b)
            dst_match = 1'b0;
        if (p >= POS_TIM_LO && p <= POS_TIM_HI)
            timing_bytes[8*(p-POS_TIM_LO) +: 8] = timing_bytes[8*(p-POS_TIM_LO) +: 8] | b;
        if (!at_end) begin
            byte_pos = (p < POS_MAX) ? 5'(p + 1) : POS_MAX;
            return;
        end
        len = p + 1;
        if (frame_ctl[2:0] == FT_DATA && frame_ctl[ACK_REQ_BIT] && len > POS_DST_HI
                && dst_match) begin
            gap = cstart - now;
            if (!regs.is_root && gap[15]) phase = now - cstart;
            else phase = '0;
            ack[0]  = ACK_B0;
            ack[1]  = ACK_B1;
            ack[2]  = seq_num;
            for (int i = 0; i < 8; i++) ack[3+i] = regs.own_addr[8*(7-i) +: 8];
            ack[11] = phase[7:0];
            ack[12] = phase[15:8];
            for (int i = 0; i < 4; i++) ack[13+i] = regs.cyc_len[8*i +: 8];
            for (int i = 0; i < ACK_LEN; i++) begin
                row           = '0;
                row.ack_valid = 1'b1;
                row.ack_byte  = ack[i];
                row.ack_last  = (i == ACK_LEN - 1);
                rows_due.push_back(row);
            end
        end else begin
            row          = '0;
            row.ack_last = 1'b1;
            if (frame_ctl[2:0] == FT_ACK && len > POS_TIM_HI && src_match) begin
                row.targets_valid = 1'b1;
                row.learned_phase = timing_bytes[15:0];
                row.learned_cycle = timing_bytes[47:16];
            end
            rows_due.push_back(row);
        end
        clear_parser();
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void compare_row();
        t_result_row want;
        if (rows_due.size() == 0) begin
            $error("result with nothing expected: tdata 0x%0h tuser 0x%0h tlast %0b",
                   i_m_axis_tdata, i_m_axis_tuser, i_m_axis_tlast);
            fail_count++;
            return;
        end
        want = rows_due.pop_front();
        check_field("ack_valid", want.ack_valid, i_m_axis_tuser[0]);
        check_field("ack_byte", want.ack_byte, i_m_axis_tdata[7:0]);
        check_field("ack_last", want.ack_last, i_m_axis_tlast);
        check_field("targets_valid", want.targets_valid, i_m_axis_tuser[1]);
        check_field("learned_phase", want.learned_phase, i_m_axis_tdata[23:8]);
        check_field("learned_cycle", want.learned_cycle, i_m_axis_tdata[55:24]);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs = '0;
            clear_parser();
            rows_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_OWN_ADDR: regs.own_addr = i_cfg_data;
                    CFG_AWAITED:  regs.awaited  = i_cfg_data;
                    CFG_IS_ROOT:  regs.is_root  = i_cfg_data[0];
                    CFG_CYC_LEN:  regs.cyc_len  = i_cfg_data[31:0];
                    default: ;
                endcase
            end
            // a result never stems from a byte taken on the same edge
            if (i_m_axis_tvalid && i_m_axis_tready) compare_row();
            if (i_s_axis_tvalid && i_s_axis_tready)
                predict_byte(i_s_axis_tdata[7:0], i_s_axis_tuser, i_s_axis_tlast,
                             i_s_axis_tdata[23:8], i_s_axis_tdata[39:24]);
        end
        o_fail_count   <= fail_count;
        o_rows_pending <= rows_due.size();
    end

endmodule

// ----- tb/tb.sv -----
// tb: clock, reset, register writes and frame stimulus for frame_ack_with_phase_info_top
// depends on fap_pkg, the block itself and fap_result_checker, which gives the failure count

module tb;
    import fap_pkg::*;

    typedef enum logic [1:0] {
        START_NONE,
        START_FIRST,
        START_STRAY
    } t_start_mode;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    wire         s_ready;
    logic [39:0] s_data = '0;
    logic        s_user = 1'b0;
    logic        s_last = 1'b0;
    wire         m_valid;
    logic        m_ready = 1'b0;
    wire  [55:0] m_data;
    wire  [1:0]  m_user;
    wire         m_last;
    logic        cfg_valid = 1'b0;
    wire         cfg_ready;
    t_cfg_idx    cfg_index = CFG_OWN_ADDR;
    logic [63:0] cfg_data = '0;
    int          fail_count;
    int          rows_pending;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          bytes_sent = 0;
    t_cfg        cur_cfg = '0;
    logic [7:0]  frame_buf[$];

    frame_ack_with_phase_info_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    fap_result_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_s_axis_tlast  (s_last),
        .i_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (m_data),
        .i_m_axis_tuser  (m_user),
        .i_m_axis_tlast  (m_last),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_rows_pending  (rows_pending)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic push_byte(input logic [7:0] b, input logic at_start, input logic at_end,
                             input logic [15:0] now, input logic [15:0] cstart);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {cstart, now, b};
        s_user  <= at_start;
        s_last  <= at_end;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input t_start_mode mode, input logic [15:0] now_end,
                              input logic [15:0] cstart_end);
        logic at_start;
        foreach (frame_buf[i]) begin
            if (i == 0) at_start = (mode != START_NONE);
            else at_start = (mode == START_STRAY && $urandom_range(15) == 0);
            if (i == frame_buf.size() - 1)
                push_byte(frame_buf[i], at_start, 1'b1, now_end, cstart_end);
            else
                push_byte(frame_buf[i], at_start, 1'b0, 16'($urandom_range(16'hffff)),
                          16'($urandom_range(16'hffff)));
        end
    endtask

    // data frames carry the destination low byte first, acks the source high byte first
    function automatic void build_frame(input logic [7:0] fc, input logic [63:0] addr,
                                        input int len, input logic ack_shape);
        frame_buf.delete();
        for (int i = 0; i < len; i++) frame_buf.push_back(8'($urandom_range(255)));
        frame_buf[0] = fc;
        for (int i = 0; i < 8; i++) begin
            if (ack_shape && 3 + i < len) frame_buf[3+i] = addr[8*(7-i) +: 8];
            if (!ack_shape && 5 + i < len) frame_buf[5+i] = addr[8*i +: 8];
        end
    endfunction

    function automatic logic [15:0] cycle_start_for(input logic [15:0] now);
        case ($urandom_range(5))
            0: return now - 16'($urandom_range(1, 100));
            1: return now + 16'($urandom_range(1, 100));
            2: return now;
            3: return now ^ 16'h8000;
            4: return now - 16'h7fff;
            default: return 16'($urandom_range(16'hffff));
        endcase
    endfunction

    function automatic t_cfg random_cfg();
        t_cfg c;
        c.own_addr = {$urandom, $urandom};
        c.awaited  = {$urandom, $urandom};
        c.is_root  = 1'($urandom_range(1));
        c.cyc_len  = $urandom;
        return c;
    endfunction

    task automatic random_frame();
        int          pick;
        int          len;
        int          flip;
        logic [7:0]  fc;
        logic [63:0] addr;
        logic [15:0] now;
        t_start_mode mode;
        pick = $urandom_range(99);
        now  = 16'($urandom_range(16'hffff));
        fc   = 8'($urandom_range(255));
        mode = ($urandom_range(9) == 0) ? START_NONE : START_FIRST;
        len  = ($urandom_range(7) == 0) ? $urandom_range(21, 40) : $urandom_range(13, 20);
        if (pick < 45) begin
            fc[2:0]          = FT_DATA;
            fc[ACK_REQ_BIT]  = 1'b1;
            build_frame(fc, cur_cfg.own_addr, len, 1'b0);
        end else if (pick < 55) begin
            fc[2:0] = FT_DATA;
            addr    = cur_cfg.own_addr;
            flip    = $urandom_range(63);
            if ($urandom_range(1)) fc[ACK_REQ_BIT] = 1'b0;
            else addr[flip] = ~addr[flip];
            build_frame(fc, addr, len, 1'b0);
        end else if (pick < 75) begin
            fc[2:0] = FT_ACK;
            build_frame(fc, cur_cfg.awaited, (len < 17) ? 17 : len, 1'b1);
        end else if (pick < 82) begin
            fc[2:0] = FT_ACK;
            addr    = cur_cfg.awaited;
            flip    = $urandom_range(63);
            addr[flip] = ~addr[flip];
            build_frame(fc, addr, $urandom_range(17, 20), 1'b1);
        end else if (pick < 90) begin
            // one byte short of what the frame type needs, or less
            fc[ACK_REQ_BIT] = 1'b1;
            if ($urandom_range(1)) begin
                fc[2:0] = FT_DATA;
                build_frame(fc, cur_cfg.own_addr, $urandom_range(1, 12), 1'b0);
            end else begin
                fc[2:0] = FT_ACK;
                build_frame(fc, cur_cfg.awaited, $urandom_range(1, 16), 1'b1);
            end
        end else begin
            mode = $urandom_range(1) ? START_STRAY : START_NONE;
            build_frame(fc, {$urandom, $urandom}, $urandom_range(1, 35),
                        1'($urandom_range(1)));
        end
        send_frame(mode, now, cycle_start_for(now));
    endtask

    task automatic run_random(input int n_bytes);
        int first;
        first = bytes_sent;
        while (bytes_sent - first < n_bytes) random_frame();
    endtask

    task automatic write_regs(input t_cfg c);
        t_cfg_idx idx;
        idx     = CFG_OWN_ADDR;
        cur_cfg = c;
        do begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            case (idx)
                CFG_OWN_ADDR: cfg_data <= c.own_addr;
                CFG_AWAITED:  cfg_data <= c.awaited;
                CFG_IS_ROOT:  cfg_data <= {63'({$urandom, $urandom}), c.is_root};
                CFG_CYC_LEN:  cfg_data <= {32'($urandom), c.cyc_len};
                default: ;
            endcase
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            idx = idx.next();
        end while (idx != CFG_OWN_ADDR);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge clk);
        while (rows_pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        write_regs('{own_addr: 64'h0123456789abcdef, awaited: 64'hfedcba9876543210,
                     is_root: 1'b0, cyc_len: 32'hdeadbeef});

        // lone byte that is both first and last
        frame_buf = '{8'hff};
        send_frame(START_FIRST, 16'h0000, 16'hffff);
        // acknowledged data frame of minimum length, cycle start just before a wrap
        build_frame(8'h21, cur_cfg.own_addr, 13, 1'b0);
        send_frame(START_FIRST, 16'h0005, 16'hfffb);
        // matching ack of minimum length with all timing bytes set
        build_frame(8'hfa, cur_cfg.awaited, 17, 1'b1);
        for (int i = POS_TIM_LO; i <= POS_TIM_HI; i++) frame_buf[i] = 8'hff;
        send_frame(START_FIRST, 16'hffff, 16'hffff);
        settle();

        send_idle_pct = 7;
        recv_idle_pct = 87;
        write_regs(random_cfg());
        run_random(110);
        settle();

        send_idle_pct = 87;
        recv_idle_pct = 7;
        write_regs('{own_addr: '1, awaited: '1, is_root: 1'b1, cyc_len: '1});
        run_random(110);
        settle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_regs('0);
        run_random(110);
        settle();

        write_regs(random_cfg());
        run_random(100);
        settle();

        if (fail_count == 0 && rows_pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
